// ===== design/vas_pkg.sv =====
// Package for the voice activity switch: transaction structs, configuration
// register codes and the mantissa and decade constants for the power thresholds.
// No dependencies.
package vas_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int ENERGY_W    = 41;
	localparam int SAMPLES_W   = 11;
	localparam int SQUARE_W    = 31;
	localparam int THR_W       = 43;
	localparam int MANT_W      = 47;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int LEVEL_W     = 8;
	localparam int ATTACK_W    = 6;
	localparam int HANG_W      = 9;
	localparam int THR_IDX_W   = 7;
	localparam int THR_FIRST_N = 10;
	localparam int THR_DEPTH   = 81;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HANG_TIME   = 3'd4;

	localparam logic signed [LEVEL_W-1:0] OPEN_MIN   = -8'sd80;
	localparam logic signed [LEVEL_W-1:0] OPEN_MAX   = -8'sd10;
	localparam logic signed [LEVEL_W-1:0] OPEN_RST   = -8'sd40;
	localparam logic signed [LEVEL_W-1:0] CLOSE_MIN  = -8'sd90;
	localparam logic signed [LEVEL_W-1:0] CLOSE_MAX  = -8'sd15;
	localparam logic signed [LEVEL_W-1:0] CLOSE_RST  = -8'sd48;
	localparam logic signed [LEVEL_W-1:0] LEVEL_GAP  = 8'sd2;
	localparam logic [CFG_DATA_W-1:0]     ATTACK_MAX = 12'd500;
	localparam logic [CFG_DATA_W-1:0]     HANG_MIN   = 12'd100;
	localparam logic [CFG_DATA_W-1:0]     HANG_MAX   = 12'd3000;
	localparam logic [ATTACK_W-1:0]       ATTACK_RST = 6'd3;
	localparam logic [HANG_W-1:0]         HANG_RST   = 9'd60;
	// Reciprocal of ten in Q16; exact floor for values up to 3000.
	localparam logic [12:0]               RECIP_TEN  = 13'd6554;

	// round(2^46 * 10^(-b/10)) for b = 0..9.
	localparam logic [MANT_W-1:0] MANT [10] = '{
		47'd70368744177664, 47'd55895880342408, 47'd44399675960745,
		47'd35267916228229, 47'd28014301639973, 47'd22252550768713,
		47'd17675829370224, 47'd14040410340938, 47'd11152694360922,
		47'd8858900024130
	};

	localparam logic [MANT_W-1:0] DEC [10] = '{
		47'd1, 47'd10, 47'd100, 47'd1000, 47'd10000, 47'd100000,
		47'd1000000, 47'd10000000, 47'd100000000, 47'd1000000000
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} in_item_t;

	typedef struct packed {
		logic                 transmit_on;
		logic                 switch_changed;
		logic [ENERGY_W-1:0]  frame_energy;
		logic [SAMPLES_W-1:0] frame_samples;
	} out_item_t;

	typedef struct packed {
		logic                enabled;
		logic                clear_runs;
		logic [ATTACK_W-1:0] attack_frames;
		logic [HANG_W-1:0]   hang_frames;
		logic [THR_W-1:0]    thr_open;
		logic [THR_W-1:0]    thr_close;
	} vas_cfg_t;

endpackage

// ===== design/vas_cfg.sv =====
// Configuration registers of the voice activity switch with clamping, the
// frame-count conversion and the registered power-threshold lookup.
// Depends on vas_pkg.
module vas_cfg
	import vas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output vas_cfg_t              cfg
);

	logic                      enabled_q;
	logic signed [LEVEL_W-1:0] open_lvl_q;
	logic signed [LEVEL_W-1:0] close_lvl_q;
	logic [ATTACK_W-1:0]       attack_frames_q;
	logic [HANG_W-1:0]         hang_frames_q;
	logic [THR_W-1:0]          thr_open_q;
	logic [THR_W-1:0]          thr_close_q;

	logic                      wr;
	logic signed [LEVEL_W-1:0] wr_level;
	logic signed [LEVEL_W-1:0] open_clamped;
	logic signed [LEVEL_W-1:0] close_clamped;
	logic [CFG_DATA_W-1:0]     attack_clamped;
	logic [CFG_DATA_W-1:0]     hang_clamped;
	logic [24:0]               attack_prod;
	logic [24:0]               hang_prod;

	logic signed [LEVEL_W-1:0] close_eff;
	logic signed [LEVEL_W-1:0] open_neg;
	logic signed [LEVEL_W-1:0] close_neg;
	logic [THR_IDX_W-1:0]      open_idx;
	logic [THR_IDX_W-1:0]      close_idx;
	logic [THR_W-1:0]          thr_tab [THR_DEPTH];

	// Threshold for -n dB is the mantissa for n mod 10 with n/10 decimal digits dropped.
	for (genvar n = 0; n < THR_DEPTH; n++) begin : g_thr
		localparam int unsigned LVL = n + THR_FIRST_N;
		localparam logic [MANT_W-1:0] TVAL = MANT[LVL % 10] / DEC[LVL / 10];
		assign thr_tab[n] = TVAL[THR_W-1:0];
	end

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign wr_level  = cfg_data[LEVEL_W-1:0];

	always_comb begin
		open_clamped = wr_level;
		if (wr_level < OPEN_MIN) begin
			open_clamped = OPEN_MIN;
		end else if (wr_level > OPEN_MAX) begin
			open_clamped = OPEN_MAX;
		end
		close_clamped = wr_level;
		if (wr_level < CLOSE_MIN) begin
			close_clamped = CLOSE_MIN;
		end else if (wr_level > CLOSE_MAX) begin
			close_clamped = CLOSE_MAX;
		end
		attack_clamped = {3'b000, cfg_data[8:0]};
		if (attack_clamped > ATTACK_MAX) begin
			attack_clamped = ATTACK_MAX;
		end
		hang_clamped = cfg_data;
		if (hang_clamped < HANG_MIN) begin
			hang_clamped = HANG_MIN;
		end else if (hang_clamped > HANG_MAX) begin
			hang_clamped = HANG_MAX;
		end
	end

	assign attack_prod = 25'(attack_clamped) * 25'(RECIP_TEN);
	assign hang_prod   = 25'(hang_clamped) * 25'(RECIP_TEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			open_lvl_q      <= OPEN_RST;
			close_lvl_q     <= CLOSE_RST;
			attack_frames_q <= ATTACK_RST;
			hang_frames_q   <= HANG_RST;
		end else if (wr) begin
			case (cfg_index)
				REG_ENABLED:     enabled_q       <= cfg_data[0];
				REG_OPEN_LEVEL:  open_lvl_q      <= open_clamped;
				REG_CLOSE_LEVEL: close_lvl_q     <= close_clamped;
				REG_ATTACK_TIME: attack_frames_q <= attack_prod[16 +: ATTACK_W];
				REG_HANG_TIME:   hang_frames_q   <= hang_prod[16 +: HANG_W];
				default:         ;
			endcase
		end
	end

	always_comb begin
		close_eff = close_lvl_q;
		if (close_lvl_q > open_lvl_q - LEVEL_GAP) begin
			close_eff = open_lvl_q - LEVEL_GAP;
		end
		open_neg  = -open_lvl_q;
		close_neg = -close_eff;
		open_idx  = open_neg[THR_IDX_W-1:0] - THR_IDX_W'(THR_FIRST_N);
		close_idx = close_neg[THR_IDX_W-1:0] - THR_IDX_W'(THR_FIRST_N);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_open_q  <= '0;
			thr_close_q <= '0;
		end else begin
			thr_open_q  <= (open_idx < THR_IDX_W'(THR_DEPTH)) ? thr_tab[open_idx] : '0;
			thr_close_q <= (close_idx < THR_IDX_W'(THR_DEPTH)) ? thr_tab[close_idx] : '0;
		end
	end

	always_comb begin
		cfg.enabled       = enabled_q;
		cfg.clear_runs    = wr && (cfg_index inside {REG_ENABLED, REG_OPEN_LEVEL,
			REG_CLOSE_LEVEL, REG_ATTACK_TIME, REG_HANG_TIME});
		cfg.attack_frames = attack_frames_q;
		cfg.hang_frames   = hang_frames_q;
		cfg.thr_open      = thr_open_q;
		cfg.thr_close     = thr_close_q;
	end

endmodule

// ===== design/vas_accum.sv =====
// Input register, sample squaring and per-frame energy accumulation of the
// voice activity switch; hands one frame total on per frame-end transaction.
// Depends on vas_pkg.
module vas_accum
	import vas_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 1024,
	parameter int ACC_W             = $clog2(MAX_FRAME_SAMPLES) + 31,
	parameter int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             frame_valid,
	input  logic             frame_ready,
	output logic [ACC_W-1:0] frame_energy,
	output logic [CNT_W-1:0] frame_count
);

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       frame_end_s1;
	logic                       valid_s2;
	logic [SQUARE_W-1:0]        square_s2;
	logic                       frame_end_s2;
	logic                       valid_s3;
	logic [ACC_W-1:0]           energy_s3;
	logic [CNT_W-1:0]           count_s3;
	logic [ACC_W-1:0]           acc_q;
	logic [CNT_W-1:0]           cnt_q;

	logic signed [31:0] square_full;
	logic               en1;
	logic               en2;
	logic               en3;
	logic               cons2;
	logic               add_ok;
	logic [ACC_W-1:0]   acc_sum;
	logic [CNT_W-1:0]   cnt_sum;

	assign en3      = !valid_s3 || frame_ready;
	assign cons2    = valid_s2 && (!frame_end_s2 || en3);
	assign en2      = !valid_s2 || cons2;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	assign square_full = sample_s1 * sample_s1;
	assign add_ok      = cnt_q < CNT_W'(MAX_FRAME_SAMPLES);
	assign acc_sum     = acc_q + (add_ok ? ACC_W'(square_s2) : '0);
	assign cnt_sum     = cnt_q + CNT_W'(add_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			acc_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= cons2 && frame_end_s2;
			end
			if (cons2) begin
				if (frame_end_s2) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_sum;
					cnt_q <= cnt_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			sample_s1    <= in_item.sample;
			frame_end_s1 <= in_item.frame_end;
		end
		if (en2 && valid_s1) begin
			square_s2    <= square_full[SQUARE_W-1:0];
			frame_end_s2 <= frame_end_s1;
		end
		if (cons2 && frame_end_s2) begin
			energy_s3 <= acc_sum;
			count_s3  <= cnt_sum;
		end
	end

	assign frame_valid  = valid_s3;
	assign frame_energy = energy_s3;
	assign frame_count  = count_s3;

endmodule

// ===== design/vas_decide.sv =====
// Threshold products, loud and quiet decisions, attack and hang run counters,
// transmit state and the result register of the voice activity switch.
// Depends on vas_pkg.
module vas_decide
	import vas_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 1024,
	parameter int ACC_W             = $clog2(MAX_FRAME_SAMPLES) + 31,
	parameter int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vas_cfg_t         cfg,
	input  logic             frame_valid,
	output logic             frame_ready,
	input  logic [ACC_W-1:0] frame_energy,
	input  logic [CNT_W-1:0] frame_count,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item
);

	localparam int PROD_W = THR_W + CNT_W;
	localparam int CMP_W  = (ACC_W + 16 > PROD_W) ? ACC_W + 16 : PROD_W;

	logic                valid_s4;
	logic [ACC_W-1:0]    energy_s4;
	logic [CNT_W-1:0]    count_s4;
	logic [PROD_W-1:0]   prod_open_s4;
	logic [PROD_W-1:0]   prod_close_s4;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [ATTACK_W-1:0] loud_run_q;
	logic [HANG_W-1:0]   quiet_run_q;
	logic                transmit_q;

	logic                out_free;
	logic                en4;
	logic                adv;
	logic [CMP_W-1:0]    scaled;
	logic                loud;
	logic                quiet;
	logic [ATTACK_W-1:0] loud_inc;
	logic [HANG_W-1:0]   quiet_inc;
	logic [ATTACK_W-1:0] loud_n;
	logic [HANG_W-1:0]   quiet_n;
	logic                tx_n;

	assign out_free    = !out_valid_q || out_ready;
	assign en4         = !valid_s4 || out_free;
	assign frame_ready = en4;
	assign adv         = valid_s4 && out_free;

	always_comb begin
		scaled    = CMP_W'({energy_s4, 16'h0000});
		loud      = scaled >= CMP_W'(prod_open_s4);
		quiet     = scaled < CMP_W'(prod_close_s4);
		loud_inc  = loud_run_q + 1'b1;
		quiet_inc = quiet_run_q + 1'b1;
		loud_n    = loud_run_q;
		quiet_n   = quiet_run_q;
		tx_n      = transmit_q;
		if (!cfg.enabled) begin
			loud_n  = '0;
			quiet_n = '0;
			tx_n    = 1'b0;
		end else if (!transmit_q) begin
			if (loud) begin
				loud_n = loud_inc;
				if (loud_inc >= cfg.attack_frames) begin
					tx_n    = 1'b1;
					loud_n  = '0;
					quiet_n = '0;
				end
			end else begin
				loud_n = '0;
			end
		end else begin
			if (quiet) begin
				quiet_n = quiet_inc;
				if (quiet_inc >= cfg.hang_frames) begin
					tx_n    = 1'b0;
					quiet_n = '0;
				end
			end else begin
				quiet_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			loud_run_q  <= '0;
			quiet_run_q <= '0;
			transmit_q  <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= frame_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s4;
			end
			if (cfg.clear_runs) begin
				loud_run_q  <= '0;
				quiet_run_q <= '0;
			end else if (adv) begin
				loud_run_q  <= loud_n;
				quiet_run_q <= quiet_n;
			end
			if (adv) begin
				transmit_q <= tx_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && frame_valid) begin
			energy_s4     <= frame_energy;
			count_s4      <= frame_count;
			prod_open_s4  <= PROD_W'(cfg.thr_open) * PROD_W'(frame_count);
			prod_close_s4 <= PROD_W'(cfg.thr_close) * PROD_W'(frame_count);
		end
		if (adv) begin
			out_q.transmit_on    <= tx_n;
			out_q.switch_changed <= tx_n != transmit_q;
			out_q.frame_energy   <= ENERGY_W'(energy_s4);
			out_q.frame_samples  <= SAMPLES_W'(count_s4);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== design/voice_activity_switch.sv =====
// Voice-operated transmit switch: top level tying configuration, accumulation
// and decision together. Depends on vas_pkg, vas_cfg, vas_accum and vas_decide.
//
// The block accepts one audio sample per clock cycle while input ready is high
// and produces one result transaction for each sample marked as frame end
// (input register, square, accumulate, threshold product, result register).
// Samples keep flowing while a result waits at the output; input ready drops
// only once the result register is held and the four internal stages are all
// occupied. Loudness is decided by comparing the frame energy times 2^16 with a
// tabulated linear threshold times the sample count, so no logarithm is taken.
// Configuration writes are never stalled, clear the attack and hang runs when
// they name a defined register and must be issued while no frame is in flight.
module voice_activity_switch
	import vas_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ACC_W = $clog2(MAX_FRAME_SAMPLES) + 31;
	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

	vas_cfg_t         cfg;
	logic             frame_valid;
	logic             frame_ready;
	logic [ACC_W-1:0] frame_energy;
	logic [CNT_W-1:0] frame_count;

	vas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vas_accum #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
		.ACC_W             (ACC_W),
		.CNT_W             (CNT_W)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_energy (frame_energy),
		.frame_count  (frame_count)
	);

	vas_decide #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
		.ACC_W             (ACC_W),
		.CNT_W             (CNT_W)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_energy (frame_energy),
		.frame_count  (frame_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item)
	);

`ifndef SYNTH
	// Input backpressure only ever comes from a held result.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the result register was free");

	// A disabled switch never reports transmit on.
	a_disabled_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg.enabled) |-> !out_item.transmit_on)
		else $error("transmit reported on while the switch is disabled");

	// A result that reports a change to transmit on needs the switch enabled.
	a_open_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.switch_changed && out_item.transmit_on) |-> cfg.enabled)
		else $error("transmit opened while the switch is disabled");
`endif

endmodule

// ===== verif/tb_voice_activity_switch.sv =====
// Self-checking testbench for voice_activity_switch: drives audio samples and register
// writes, predicts every frame result and compares it field by field.
// Depends on vas_pkg and the voice_activity_switch RTL.
module tb_voice_activity_switch;
	import vas_pkg::*;

	localparam int FRAME_CAP     = 1024;
	localparam int MS_PER_FRAME  = 10;
	localparam int IDLE_PCT      = 22;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 40;
	localparam int REPORT_CAP    = 40;
	localparam int IDX_TOP       = (1 << CFG_IDX_W) - 1;

	typedef enum {KIND_LOUD, KIND_QUIET, KIND_NOISE} sample_kind_e;

	class vox_scoreboard;
		bit              enabled;
		int              open_lvl;
		int              close_lvl;
		int unsigned     attack_n;
		int unsigned     hang_n;
		longint unsigned energy;
		int unsigned     count;
		int unsigned     loud_run;
		int unsigned     quiet_run;
		bit              transmit;
		out_item_t       frame_reports[$];
		int              errors;

		function new();
			enabled   = 1'b0;
			open_lvl  = int'(OPEN_RST);
			close_lvl = int'(CLOSE_RST);
			attack_n  = ATTACK_RST;
			hang_n    = HANG_RST;
			energy    = 0;
			count     = 0;
			loud_run  = 0;
			quiet_run = 0;
			transmit  = 1'b0;
			errors    = 0;
		endfunction

		function int clamp_to(int v, int lo, int hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function longint unsigned power_floor(int db);
			int n;
			n = clamp_to(-db, 10, 90);
			return MANT[n % 10] / DEC[n / 10];
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			int lvl;
			lvl = int'($signed(data[LEVEL_W-1:0]));
			case (idx)
				REG_ENABLED:     enabled = data[0];
				REG_OPEN_LEVEL:  open_lvl = clamp_to(lvl, OPEN_MIN, OPEN_MAX);
				REG_CLOSE_LEVEL: close_lvl = clamp_to(lvl, CLOSE_MIN, CLOSE_MAX);
				REG_ATTACK_TIME: attack_n = clamp_to(int'(data[8:0]), 0, ATTACK_MAX) / MS_PER_FRAME;
				REG_HANG_TIME:   hang_n = clamp_to(int'(data), HANG_MIN, HANG_MAX) / MS_PER_FRAME;
				default:         return;
			endcase
			loud_run  = 0;
			quiet_run = 0;
		endfunction

		function void take_sample(in_item_t it);
			longint          s;
			longint unsigned scaled;
			int              close_eff;
			bit              was_on;
			out_item_t       due;
			s = longint'($signed(it.sample));
			if (count < FRAME_CAP) begin
				energy += longint'(s * s);
				count++;
			end
			if (!it.frame_end) return;
			scaled    = energy << 16;
			was_on    = transmit;
			close_eff = close_lvl;
			if (close_eff > open_lvl - int'(LEVEL_GAP)) close_eff = open_lvl - int'(LEVEL_GAP);
			if (!enabled) begin
				loud_run  = 0;
				quiet_run = 0;
				transmit  = 1'b0;
			end else if (!transmit) begin
				if (scaled >= power_floor(open_lvl) * longint'(count)) begin
					loud_run = (loud_run + 1) % (1 << ATTACK_W);
					if (loud_run >= attack_n) begin
						transmit  = 1'b1;
						loud_run  = 0;
						quiet_run = 0;
					end
				end else begin
					loud_run = 0;
				end
			end else begin
				if (scaled < power_floor(close_eff) * longint'(count)) begin
					quiet_run = (quiet_run + 1) % (1 << HANG_W);
					if (quiet_run >= hang_n) begin
						transmit  = 1'b0;
						quiet_run = 0;
					end
				end else begin
					quiet_run = 0;
				end
			end
			due.transmit_on    = transmit;
			due.switch_changed = transmit != was_on;
			due.frame_energy   = energy[ENERGY_W-1:0];
			due.frame_samples  = count[SAMPLES_W-1:0];
			frame_reports.push_back(due);
			energy = 0;
			count  = 0;
		endfunction

		task flag(string msg);
			errors++;
			if (errors <= REPORT_CAP) $display("mismatch: %s", msg);
		endtask

		task check_frame(out_item_t got);
			out_item_t due;
			if (frame_reports.size() == 0) begin
				flag($sformatf("result transaction with nothing pending, energy %0d",
					got.frame_energy));
				return;
			end
			due = frame_reports.pop_front();
			if (got.transmit_on !== due.transmit_on)
				flag($sformatf("transmit_on %b, predicted %b", got.transmit_on, due.transmit_on));
			if (got.switch_changed !== due.switch_changed)
				flag($sformatf("switch_changed %b, predicted %b", got.switch_changed,
					due.switch_changed));
			if (got.frame_energy !== due.frame_energy)
				flag($sformatf("frame_energy %0d, predicted %0d", got.frame_energy,
					due.frame_energy));
			if (got.frame_samples !== due.frame_samples)
				flag($sformatf("frame_samples %0d, predicted %0d", got.frame_samples,
					due.frame_samples));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vox_scoreboard sb = new();
	bit            steady;
	int            stall_cycles;
	int            random_items;

	voice_activity_switch #(
		.MAX_FRAME_SAMPLES(FRAME_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit lull();
		return !steady && roll(IDLE_PCT);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_kind_e kind);
		int                         v;
		logic signed [SAMPLE_W-1:0] x;
		case (kind)
			KIND_LOUD: begin
				v = $urandom_range(12000, 32767);
				if (roll(50)) v = -v;
				if (roll(5)) v = -32768;
				x = v[SAMPLE_W-1:0];
			end
			KIND_QUIET: begin
				v = $urandom_range(0, 2);
				v = v - 1;
				x = v[SAMPLE_W-1:0];
			end
			default: begin
				v = $urandom;
				x = v[SAMPLE_W-1:0];
				x = x >>> $urandom_range(0, SAMPLE_W - 1);
			end
		endcase
		return x;
	endfunction

	task automatic push_sample(logic signed [SAMPLE_W-1:0] s, logic fe);
		in_item_t it;
		bit       hit;
		it.sample    = s;
		it.frame_end = fe;
		while (lull()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(negedge clk);
			hit = in_ready;
			@(posedge clk);
		end while (!hit);
		sb.take_sample(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit hit;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			hit = cfg_ready;
			@(posedge clk);
		end while (!hit);
		sb.write_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.frame_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_frames(int n_items, int len_max);
		int          sent;
		int          len;
		int unsigned need;
		int          run_left;
		bit          loud;
		sent     = 0;
		run_left = 0;
		loud     = 1'b0;
		while (sent < n_items) begin
			if (run_left <= 0) begin
				loud     = !loud;
				need     = loud ? sb.attack_n : sb.hang_n;
				run_left = roll(50) ? need + $urandom_range(0, 3) : $urandom_range(1, need + 1);
				if (run_left < 1) run_left = 1;
			end
			len = $urandom_range(1, len_max);
			for (int i = 0; i < len; i++) begin
				push_sample(pick_sample(roll(12) ? KIND_NOISE : (loud ? KIND_LOUD : KIND_QUIET)),
					i == len - 1);
			end
			sent     += len;
			run_left -= 1;
		end
		random_items += sent;
	endtask

	task automatic shuffle_config();
		logic [CFG_DATA_W-1:0] d;
		int                    lvl;
		if (roll(60)) begin
			d    = CFG_DATA_W'($urandom);
			d[0] = roll(88);
			write_reg(REG_ENABLED, d);
		end
		if (roll(60)) begin
			lvl = $urandom_range(10, 80);
			d   = roll(70) ? CFG_DATA_W'(-lvl) : CFG_DATA_W'($urandom);
			write_reg(REG_OPEN_LEVEL, d);
		end
		if (roll(60)) begin
			lvl = $urandom_range(15, 90);
			d   = roll(70) ? CFG_DATA_W'(-lvl) : CFG_DATA_W'($urandom);
			write_reg(REG_CLOSE_LEVEL, d);
		end
		if (roll(60)) begin
			d = roll(70) ? CFG_DATA_W'($urandom_range(0, 500)) : CFG_DATA_W'($urandom);
			write_reg(REG_ATTACK_TIME, d);
		end
		if (roll(60)) begin
			if (roll(70)) d = CFG_DATA_W'($urandom_range(100, 700));
			else if (roll(30)) d = CFG_DATA_W'($urandom_range(100, 3000));
			else d = CFG_DATA_W'($urandom);
			write_reg(REG_HANG_TIME, d);
		end
		if (roll(25))
			write_reg(CFG_IDX_W'($urandom_range(REG_HANG_TIME + 1, IDX_TOP)),
				CFG_DATA_W'($urandom));
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_ready <= !lull();
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_frame(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_voice_activity_switch: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		clk          = 1'b0;
		arst_n       = 1'b0;
		steady       = 1'b0;
		stall_cycles = 0;
		random_items = 0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled after reset: frames report but never transmit.
		push_sample(16'sd32767, 1'b0);
		push_sample(-16'sd32768, 1'b1);
		push_sample(16'sd0, 1'b1);
		settle();
		write_reg(REG_ENABLED, 12'd1);
		write_reg(REG_ATTACK_TIME, 12'd0);
		// With no attack time a single loud frame opens; a silent frame counts as quiet.
		push_sample(-16'sd32768, 1'b1);
		push_sample(16'sd0, 1'b1);
		push_sample(16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b1);
		push_sample(16'sd32767, 1'b1);
		settle();
		write_reg(CFG_IDX_W'(REG_HANG_TIME + 1), 12'hFFF);
		push_sample(16'sd0, 1'b1);
		settle();
		write_reg(REG_ENABLED, 12'hFFE);
		push_sample(16'sd12345, 1'b1);
		push_sample(16'sd0, 1'b1);
		settle();
		write_reg(REG_ENABLED, 12'd1);
		// Overlong frame: samples past the cap are neither summed nor counted.
		steady = 1'b1;
		for (int i = 0; i < FRAME_CAP + 1; i++) push_sample(-16'sd32768, 1'b0);
		push_sample(16'sd32767, 1'b1);
		push_sample(16'sd2, 1'b1);
		steady = 1'b0;

		settle();
		write_reg(REG_OPEN_LEVEL, CFG_DATA_W'(-10));
		write_reg(REG_CLOSE_LEVEL, CFG_DATA_W'(-15));
		write_reg(REG_ATTACK_TIME, 12'd0);
		write_reg(REG_HANG_TIME, 12'd100);
		run_frames(30, 3);

		settle();
		write_reg(REG_OPEN_LEVEL, CFG_DATA_W'(-80));
		write_reg(REG_CLOSE_LEVEL, CFG_DATA_W'(-90));
		write_reg(REG_ATTACK_TIME, 12'd500);
		write_reg(REG_HANG_TIME, 12'd3000);
		run_frames(30, 1);

		settle();
		write_reg(REG_OPEN_LEVEL, 12'h07F);
		write_reg(REG_CLOSE_LEVEL, 12'hF80);
		write_reg(REG_ATTACK_TIME, 12'h1FF);
		write_reg(REG_HANG_TIME, 12'hFFF);
		run_frames(15, 2);

		settle();
		write_reg(REG_OPEN_LEVEL, 12'h080);
		write_reg(REG_ATTACK_TIME, 12'd25);
		write_reg(REG_HANG_TIME, 12'd0);
		run_frames(15, 4);

		settle();
		write_reg(REG_OPEN_LEVEL, CFG_DATA_W'(-40));
		write_reg(REG_CLOSE_LEVEL, CFG_DATA_W'(-20));
		write_reg(REG_ATTACK_TIME, 12'd30);
		write_reg(REG_HANG_TIME, 12'd150);
		run_frames(20, 4);

		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			shuffle_config();
			steady = phase == 2;
			run_frames($urandom_range(10, 20), sb.hang_n > 100 ? 2 : $urandom_range(1, 12));
			phase++;
		end
		steady = 1'b0;

		settle();
		if (sb.frame_reports.size() != 0)
			sb.flag($sformatf("%0d result transactions never arrived", sb.frame_reports.size()));
		if (sb.errors == 0)
			$display("tb_voice_activity_switch: done, clean");
		else
			$display("tb_voice_activity_switch: done, errors");
		$finish;
	end

endmodule
